// File: hw/rtl/slf_pkg.sv
// Shared types, constants and the quarter-wave sine function for the flanger.
package slf_pkg;

   // Field and port widths
   localparam int SAMPLE_W    = 16;
   localparam int OUT_W       = 17;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int SPAN_W      = 12;
   localparam int PHASE_W     = 32;
   localparam int WEIGHT_W    = 17;
   localparam int DELAY_W     = 13;
   localparam int PROD_W      = SPAN_W + WEIGHT_W;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   // Parameter defaults
   localparam int HISTORY_DEPTH_DEF   = 1024;
   localparam int SINE_TABLE_BITS_DEF = 8;

   // Q16 one half, used as weight bias and as rounding term
   localparam logic [WEIGHT_W-1:0] HALF_Q16 = 17'd32768;

   // Polynomial coefficients of the quarter-wave curve, Q16
   localparam logic [63:0] SIN_A = 64'd102944;
   localparam logic [63:0] SIN_B = 64'd42047;
   localparam logic [63:0] SIN_C = 64'd4640;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_SPAN = 1'b0,
      CSR_PHASE_STEP = 1'b1
   } csr_index_type;

   // Quarter-wave sine, x in Q16 within 0..65536, result Q15 within 0..32768.
   // Only called with constant arguments to build the table.
   function automatic logic [SAMPLE_W-1:0] quarter_sine(input logic [16:0] x);
      logic [63:0] xx;
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] s;
      xx = (64'(x) * 64'(x)) >> 16;
      t  = SIN_B - ((xx * SIN_C) >> 16);
      u  = SIN_A - ((xx * t) >> 16);
      s  = (64'(x) * u + 64'd65536) >> 17;
      if (s > 64'd32768) begin
         s = 64'd32768;
      end
      return s[SAMPLE_W-1:0];
   endfunction

endpackage

// File: hw/rtl/slf_sine_rom.sv
// Sine table lookup: phase index to Q16 delay weight (1 + sin) / 2.
module slf_sine_rom import slf_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic [SINE_TABLE_BITS-1:0] phase_idx,
   output logic [WEIGHT_W-1:0]        weight
);

   localparam int QW     = 1 << (SINE_TABLE_BITS - 2);
   localparam int LUT_AW = SINE_TABLE_BITS - 1;
   localparam int XSHIFT = 18 - SINE_TABLE_BITS;

   logic [SAMPLE_W-1:0] lut [QW+1];
   logic [1:0]                  quad;
   logic [SINE_TABLE_BITS-3:0]  rem;
   logic [LUT_AW-1:0]           lut_idx;
   logic [SAMPLE_W-1:0]         mag;

   // Build the quarter-wave table from constants, one entry past the quarter
   for (genvar g = 0; g <= QW; g++) begin : g_lut
      assign lut[g] = quarter_sine(17'(g << XSHIFT));
   end

   // Fold the phase into the first quadrant, then apply the sign as a bias
   always_comb begin
      quad    = phase_idx[SINE_TABLE_BITS-1 -: 2];
      rem     = phase_idx[SINE_TABLE_BITS-3:0];
      lut_idx = quad[0] ? (LUT_AW'(QW) - {1'b0, rem}) : {1'b0, rem};
      mag     = lut[lut_idx];
      weight  = quad[1] ? (HALF_Q16 - {1'b0, mag}) : (HALF_Q16 + {1'b0, mag});
   end

endmodule

// File: hw/rtl/slf_history.sv
// Circular sample history: one write port and one registered read port.
module slf_history import slf_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             step_en,
   input  logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
   input  logic [SAMPLE_W-1:0]              wr_data,
   input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
   output logic [SAMPLE_W-1:0]              rd_data_ff
);

   logic [SAMPLE_W-1:0] mem [HISTORY_DEPTH];

   // Read old contents before the same-cycle write lands
   always_ff @(posedge clock) begin
      if (step_en) begin
         mem[wr_addr] <= wr_data;
         rd_data_ff   <= mem[rd_addr];
      end
   end

endmodule

// File: hw/rtl/sine_lfo_flanger.sv
// Flanger top level: sine LFO modulated delay, five-stage pipeline.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  req     | in        | req_tvalid/req_tready | req_tdata: sample_in[15:0]
//  rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata: sample_out[16:0], pad
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One sample per clock sustained while rsp_tready is high; an accepted sample
// passes the input, weight, delay, history read and output registers, the last driving rsp_tvalid.
// Each stage moves forward when the stage after it is empty or moving, so
// bubbles collapse and input keeps filling empty stages while a result waits.
// Reset clears all valid bits, the LFO phase, write pointer, fill count and
// configuration registers. The history is not cleared: entries beyond the fill
// count read as silence. csr_ready is always high.
module sine_lfo_flanger import slf_pkg::*; #(
   parameter int HISTORY_DEPTH   = HISTORY_DEPTH_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] sample_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [16:0] sample_out, [23:17] zero
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW   = $clog2(HISTORY_DEPTH);
   localparam int FW   = $clog2(HISTORY_DEPTH + 1);
   localparam int CMPW = ((FW > DELAY_W) ? FW : DELAY_W) + 1;
   localparam int TB   = SINE_TABLE_BITS;

   // Configuration registers
   logic [SPAN_W-1:0]  span_ff,  span_in;
   logic [PHASE_W-1:0] step_ff,  step_in;

   // Running state advanced per accepted transaction
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [AW-1:0]      wp_ff,    wp_in;
   logic [FW-1:0]      fill_ff,  fill_in;

   // Pipeline valids and stage enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;
   logic req_acc;
   logic step_en;

   // Stage payloads
   logic [SAMPLE_W-1:0] x1_ff, x2_ff, x3_ff, x4_ff;
   logic [TB-1:0]       idx1_ff;
   logic [AW-1:0]       wp1_ff, wp2_ff, wp3_ff;
   logic [FW-1:0]       fill1_ff, fill2_ff, fill3_ff;
   logic [WEIGHT_W-1:0] w2_in, w2_ff;
   logic [DELAY_W-1:0]  d3_in, d3_ff;
   logic                hit3, hit4_ff;
   logic                live3, live4_ff;
   logic [PROD_W-1:0]   prod;
   logic [CMPW-1:0]     rd_sum;
   logic [AW-1:0]       rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic signed [OUT_W-1:0] dry_ext, wet_ext, out_in, out_ff;

   // Stall chain: a stage may load when it is empty or its successor loads
   assign en5        = !v5_ff || rsp_tready;
   assign en4        = !v4_ff || en5;
   assign en3        = !v3_ff || en4;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;
   assign req_acc    = req_tvalid && en1;
   assign step_en    = en4 && v3_ff;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - OUT_W){1'b0}}, out_ff};

   // Decode register writes
   always_comb begin
      span_in = span_ff;
      step_in = step_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DELAY_SPAN: span_in = csr_data[SPAN_W-1:0];
            CSR_PHASE_STEP: step_in = csr_data[PHASE_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance phase, write pointer and saturating fill count per transaction
   always_comb begin
      phase_in = phase_ff + step_ff;
      wp_in    = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      fill_in  = (fill_ff == FW'(HISTORY_DEPTH)) ? fill_ff : fill_ff + 1'b1;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff  <= '0;
         step_ff  <= '0;
         phase_ff <= '0;
         wp_ff    <= '0;
         fill_ff  <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
      end else begin
         span_ff <= span_in;
         step_ff <= step_in;
         if (req_acc) begin
            phase_ff <= phase_in;
            wp_ff    <= wp_in;
            fill_ff  <= fill_in;
         end
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // Stage 2 logic: sine weight from the captured phase index
   slf_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine_rom (
      .phase_idx (idx1_ff),
      .weight    (w2_in)
   );

   // Stage 3 logic: delay = round(span * weight / 2^16)
   always_comb begin
      prod  = PROD_W'(span_ff) * PROD_W'(w2_ff);
      d3_in = DELAY_W'((prod + PROD_W'(HALF_Q16)) >> 16);
   end

   // History read address, whether the tap is in range and whether it is written
   always_comb begin
      hit3    = (d3_ff != '0) && (CMPW'(d3_ff) <= CMPW'(HISTORY_DEPTH));
      live3   = CMPW'(d3_ff) <= CMPW'(fill3_ff);
      rd_sum  = CMPW'(wp3_ff) + CMPW'(HISTORY_DEPTH) - CMPW'(d3_ff);
      rd_addr = (rd_sum >= CMPW'(HISTORY_DEPTH)) ?
                AW'(rd_sum - CMPW'(HISTORY_DEPTH)) : AW'(rd_sum);
   end

   slf_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock      (clock),
      .step_en    (step_en),
      .wr_addr    (wp3_ff),
      .wr_data    (x3_ff),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Stage 5 logic: dry plus tap, silence for an unwritten tap, or double dry
   // when the tap is out of range
   always_comb begin
      dry_ext = {x4_ff[SAMPLE_W-1], x4_ff};
      if (!hit4_ff) begin
         wet_ext = dry_ext;
      end else if (live4_ff) begin
         wet_ext = {rd_data[SAMPLE_W-1], rd_data};
      end else begin
         wet_ext = '0;
      end
      out_in  = dry_ext + wet_ext;
   end

   // Pipeline payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x1_ff    <= req_tdata[SAMPLE_W-1:0];
         idx1_ff  <= phase_ff[PHASE_W-1 -: TB];
         wp1_ff   <= wp_ff;
         fill1_ff <= fill_ff;
      end
      if (en2 && v1_ff) begin
         x2_ff    <= x1_ff;
         w2_ff    <= w2_in;
         wp2_ff   <= wp1_ff;
         fill2_ff <= fill1_ff;
      end
      if (en3 && v2_ff) begin
         x3_ff    <= x2_ff;
         d3_ff    <= d3_in;
         wp3_ff   <= wp2_ff;
         fill3_ff <= fill2_ff;
      end
      if (step_en) begin
         x4_ff    <= x3_ff;
         hit4_ff  <= hit3;
         live4_ff <= live3;
      end
      if (en5 && v4_ff) begin
         out_ff <= out_in;
      end
   end

endmodule

// File: hw/rtl/slf_checker.sv
// Port-level checks for the flanger, bound to the top level.
module slf_checker import slf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int PIPE_DEPTH = 5;

   logic [3:0] inflight_ff, inflight_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Track transactions accepted but not yet delivered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_acc && !rsp_acc) inflight_in = inflight_ff + 1'b1;
      if (rsp_acc && !req_acc) inflight_in = inflight_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != 4'd0)
      else $error("result without an outstanding transaction");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 4'(PIPE_DEPTH))
      else $error("more transactions in flight than pipeline stages");

   a_flow_through: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains freely");

endmodule

bind sine_lfo_flanger slf_checker u_slf_checker (.*);
